// File: hw/rtl/ttq_pkg.sv
// ----------------------------------------------------------------------------
// ttq_pkg: shared types and constants
// Queue depth, fire cap, slot layout and result kinds for the timer queue.
// ----------------------------------------------------------------------------
package ttq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int FIRE_LIMIT  = 64;
  localparam int TIME_W      = 48;
  localparam int ID_W        = 16;
  localparam int TAG_W       = 16;
  localparam int HELD_W      = 6;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FIRE_W      = $clog2(FIRE_LIMIT + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_FIRED     = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] ivl;
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
  } ttq_entry_t;

  localparam int ENTRY_W = $bits(ttq_entry_t);

endpackage

// File: hw/rtl/timed_task_queue.sv
// ----------------------------------------------------------------------------
// timed_task_queue: sorted timer queue
// Keeps timed tasks sorted by due time; add, cancel and tick requests.
// ----------------------------------------------------------------------------
// Add and cancel walk the slots one at a time and then shift the entries behind
// the found position; each firing of a tick costs one slot-memory pass to remove
// the head and, for a repeating task whose next due time does not overflow, one
// to re-insert it. One request at a time: in_tready is high only while idle.
// Reset clears slot count, id counter, state, pending flag and output valid; slots stay
// undefined, as only entries below the count are ever read.
module timed_task_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_time[47:0], repeat_interval[95:48], action_tag[111:96], cancel_id[127:112],
  // now_time[175:128]
  input  logic [175:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // task_id[15:0], fired_tag[31:16], due_time[79:32], entries_held[85:80], zero[87:86]
  output logic [87:0]  out_tdata,
  // kind[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);
  import ttq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRCH    = 4'd1;
  localparam logic [3:0] S_SRCH_W  = 4'd2;
  localparam logic [3:0] S_SHD     = 4'd3;
  localparam logic [3:0] S_SHD_W   = 4'd4;
  localparam logic [3:0] S_CSRCH   = 4'd5;
  localparam logic [3:0] S_CSRCH_W = 4'd6;
  localparam logic [3:0] S_SHU     = 4'd7;
  localparam logic [3:0] S_SHU_W   = 4'd8;
  localparam logic [3:0] S_TCHK    = 4'd9;
  localparam logic [3:0] S_TCHK_W  = 4'd10;
  localparam logic [3:0] S_TFLUSH  = 4'd11;
  localparam logic [3:0] S_TPEND   = 4'd12;
  localparam logic [3:0] S_TEND    = 4'd13;
  localparam logic [3:0] S_EMIT    = 4'd14;
  localparam logic [3:0] S_RMDONE  = 4'd15;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [ID_W-1:0]   cid_r, cid_nxt;
  logic [TIME_W-1:0] key_r, key_nxt;
  ttq_entry_t        ins_r, ins_nxt;
  ttq_entry_t        fire_r, fire_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [FIRE_W-1:0] nfire_r, nfire_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  logic [2:0]        res_kind_r, res_kind_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;

  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [TAG_W-1:0]  pend_tag_r, pend_tag_nxt;
  logic [TIME_W-1:0] pend_due_r, pend_due_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;

  logic              ov_r, ov_nxt;
  logic [2:0]        ok_r, ok_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [TAG_W-1:0]  otag_r, otag_nxt;
  logic [TIME_W-1:0] odue_r, odue_nxt;
  logic [HELD_W-1:0] oheld_r, oheld_nxt;
  logic              olast_r, olast_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  ttq_entry_t        wr_data, rd_data;
  logic [ENTRY_W-1:0] rd_raw;
  logic              out_free;
  logic [TIME_W:0]   sum;

  ttq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  assign rd_data  = ttq_entry_t'(rd_raw);
  assign out_free = !ov_r || out_tready;
  assign sum      = {1'b0, fire_r.due} + {1'b0, fire_r.ivl};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = ok_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {2'b00, oheld_r, odue_r, otag_r, oid_r};

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    now_nxt      = now_r;
    cid_nxt      = cid_r;
    key_nxt      = key_r;
    ins_nxt      = ins_r;
    fire_nxt     = fire_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    nfire_nxt    = nfire_r;
    next_id_nxt  = next_id_r;
    res_kind_nxt = res_kind_r;
    res_id_nxt   = res_id_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_tag_nxt = pend_tag_r;
    pend_due_nxt = pend_due_r;
    pend_cnt_nxt = pend_cnt_r;
    ov_nxt       = ov_r && !out_tready;
    ok_nxt       = ok_r;
    oid_nxt      = oid_r;
    otag_nxt     = otag_r;
    odue_nxt     = odue_r;
    oheld_nxt    = oheld_r;
    olast_nxt    = olast_r;
    wr_en        = 1'b0;
    wr_addr      = ADDR_W'(idx_r);
    wr_data      = rd_data;
    rd_addr      = ADDR_W'(idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_tuser;
          now_nxt = in_tdata[175:128];
          cid_nxt = in_tdata[127:112];
          idx_nxt = '0;
          case (in_tuser)
            OP_ADD: begin
              ins_nxt = '{due: in_tdata[47:0], ivl: in_tdata[95:48],
                          id: next_id_r, tag: in_tdata[111:96]};
              key_nxt = in_tdata[47:0];
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_kind_nxt = KIND_FULL;
                res_id_nxt   = '0;
                state_nxt    = S_EMIT;
              end else if (in_tdata[47:0] == '0) begin
                pos_nxt   = '0;
                idx_nxt   = count_r;
                state_nxt = S_SHD;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            OP_CANCEL: state_nxt = S_CSRCH;
            OP_TICK: begin
              nfire_nxt = '0;
              state_nxt = S_TCHK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SRCH: begin
        if (idx_r == count_r) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          state_nxt = S_SHD;
        end else begin
          state_nxt = S_SRCH_W;
        end
      end
      S_SRCH_W: begin
        if (rd_data.due > key_r) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          state_nxt = S_SHD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SHD: begin
        rd_addr = ADDR_W'(idx_r - 1'b1);
        if (idx_r == pos_r) begin
          wr_en     = 1'b1;
          wr_addr   = ADDR_W'(pos_r);
          wr_data   = ins_r;
          count_nxt = count_r + 1'b1;
          if (op_r == OP_ADD) begin
            next_id_nxt  = next_id_r + 1'b1;
            res_kind_nxt = KIND_ADDED;
            res_id_nxt   = ins_r.id;
            state_nxt    = S_EMIT;
          end else begin
            state_nxt = S_TPEND;
          end
        end else begin
          state_nxt = S_SHD_W;
        end
      end
      S_SHD_W: begin
        wr_en     = 1'b1;
        wr_addr   = ADDR_W'(idx_r);
        wr_data   = rd_data;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_SHD;
      end
      S_CSRCH: begin
        if (idx_r == count_r) begin
          res_kind_nxt = KIND_NOT_FOUND;
          res_id_nxt   = cid_r;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_CSRCH_W;
        end
      end
      S_CSRCH_W: begin
        if (rd_data.id == cid_r) begin
          state_nxt = S_SHU;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CSRCH;
        end
      end
      S_SHU: begin
        rd_addr = ADDR_W'(idx_r + 1'b1);
        if ((idx_r + 1'b1) >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RMDONE;
        end else begin
          state_nxt = S_SHU_W;
        end
      end
      S_SHU_W: begin
        wr_en     = 1'b1;
        wr_addr   = ADDR_W'(idx_r);
        wr_data   = rd_data;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_SHU;
      end
      S_RMDONE: begin
        if (op_r == OP_CANCEL) begin
          res_kind_nxt = KIND_CANCELLED;
          res_id_nxt   = cid_r;
          state_nxt    = S_EMIT;
        end else if (fire_r.ivl != '0 && !sum[TIME_W]) begin
          ins_nxt     = fire_r;
          ins_nxt.due = sum[TIME_W-1:0];
          key_nxt     = sum[TIME_W-1:0];
          idx_nxt     = '0;
          state_nxt   = S_SRCH;
        end else begin
          state_nxt = S_TPEND;
        end
      end
      S_TCHK: begin
        rd_addr = '0;
        if (nfire_r == FIRE_W'(FIRE_LIMIT) || count_r == '0) begin
          state_nxt = S_TEND;
        end else begin
          state_nxt = S_TCHK_W;
        end
      end
      S_TCHK_W: begin
        if (rd_data.due <= now_r) begin
          fire_nxt  = rd_data;
          state_nxt = S_TFLUSH;
        end else begin
          state_nxt = S_TEND;
        end
      end
      S_TFLUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            ov_nxt    = 1'b1;
            ok_nxt    = KIND_FIRED;
            oid_nxt   = pend_id_r;
            otag_nxt  = pend_tag_r;
            odue_nxt  = pend_due_r;
            oheld_nxt = HELD_W'(pend_cnt_r);
            olast_nxt = 1'b0;
          end
          pend_v_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_SHU;
        end
      end
      S_TPEND: begin
        pend_v_nxt   = 1'b1;
        pend_id_nxt  = fire_r.id;
        pend_tag_nxt = fire_r.tag;
        pend_due_nxt = fire_r.due;
        pend_cnt_nxt = count_r;
        nfire_nxt    = nfire_r + 1'b1;
        state_nxt    = S_TCHK;
      end
      S_TEND: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ov_nxt     = 1'b1;
          ok_nxt     = KIND_FIRED;
          oid_nxt    = pend_id_r;
          otag_nxt   = pend_tag_r;
          odue_nxt   = pend_due_r;
          oheld_nxt  = HELD_W'(pend_cnt_r);
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = res_kind_r;
          oid_nxt   = res_id_r;
          otag_nxt  = '0;
          odue_nxt  = '0;
          oheld_nxt = HELD_W'(count_r);
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      next_id_r <= '0;
      pend_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      pend_v_r  <= pend_v_nxt;
      ov_r      <= ov_nxt;
    end
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    cid_r      <= cid_nxt;
    key_r      <= key_nxt;
    ins_r      <= ins_nxt;
    fire_r     <= fire_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    nfire_r    <= nfire_nxt;
    res_kind_r <= res_kind_nxt;
    res_id_r   <= res_id_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_tag_r <= pend_tag_nxt;
    pend_due_r <= pend_due_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    ok_r       <= ok_nxt;
    oid_r      <= oid_nxt;
    otag_r     <= otag_nxt;
    odue_r     <= odue_nxt;
    oheld_r    <= oheld_nxt;
    olast_r    <= olast_nxt;
  end

endmodule

// File: hw/rtl/ttq_ram.sv
// ----------------------------------------------------------------------------
// ttq_ram: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttq_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 128,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/ttq_checker.sv
// ----------------------------------------------------------------------------
// ttq_checker: port checks for the timer queue
// Watches request and result channels of the top level.
// ----------------------------------------------------------------------------
module ttq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [87:0]  out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);
  import ttq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != 2'd3 |=> !in_tready)
    else $error("request accepted while busy");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_FIRED |-> out_tlast)
    else $error("non-fire result without last");

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[85:80] <= 6'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

endmodule

bind timed_task_queue ttq_checker u_ttq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
